### rtl/cmuvp_pkg.sv
// Shared definitions for the cube-map face projection block.
// Holds parameter defaults, face codes and the sideband struct; no dependencies.
`default_nettype none

package cmuvp_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int UV_FRAC_BITS_DEF = 16;

	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	// Per-item data that rides alongside the divider stages.
	typedef struct packed {
		logic [2:0] face;
		logic       degenerate;
	} cmuvp_side_t;

endpackage

`default_nettype wire

### rtl/cube_map_uv_projection.sv
// Cube-map face projection: one vertex position in, face and texture u/v out.
// Throughput: one item per clock; busy stays low after reset, the pipeline never stalls.
// Depth is set by the divider: integer part in its first stage, then one fraction bit per stage.
// Reset (arst_n low) clears all valid bits and holds busy high until the first edge after release.
// Instantiates cmuvp_div; uses cmuvp_pkg.
`default_nettype none

module cube_map_uv_projection
	import cmuvp_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [COORD_WIDTH-1:0]  pos_x,
	input  wire logic [COORD_WIDTH-1:0]  pos_y,
	input  wire logic [COORD_WIDTH-1:0]  pos_z,
	output logic                         done,
	output logic [UV_FRAC_BITS:0]        u_coord,
	output logic [UV_FRAC_BITS:0]        v_coord,
	output logic [2:0]                   face,
	output logic                         degenerate
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = UV_FRAC_BITS;
	// edges from the accepting edge to the edge that takes the result
	localparam int LAT = F + 4;
	localparam logic [F:0] UV_HALF = {2'b01, {(F-1){1'b0}}};
	localparam logic [F:0] UV_ONE  = {1'b1, {F{1'b0}}};

	logic accept;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// stage 1: register coordinates and their magnitudes
	logic         vld_s1;
	logic [W-1:0] x_s1, y_s1, z_s1;
	logic [W-1:0] ax_s1, ay_s1, az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= pos_x;
		y_s1  <= pos_y;
		z_s1  <= pos_z;
		// most negative value wraps to 2^(W-1), which is its exact magnitude
		ax_s1 <= pos_x[W-1] ? (~pos_x + W'(1)) : pos_x;
		ay_s1 <= pos_y[W-1] ? (~pos_y + W'(1)) : pos_y;
		az_s1 <= pos_z[W-1] ? (~pos_z + W'(1)) : pos_z;
	end

	// stage 2: pick the major axis, the face and the signed (uc, vc) pair
	logic [W:0]   xe_c, ye_c, ze_c;
	logic         zsel_c, ysel_c;
	logic         xpos_c, ypos_c, zpos_c;
	logic [2:0]   face_c;
	logic [W-1:0] m_c;
	logic [W:0]   uc_c, vc_c;

	assign xe_c   = {x_s1[W-1], x_s1};
	assign ye_c   = {y_s1[W-1], y_s1};
	assign ze_c   = {z_s1[W-1], z_s1};
	assign zsel_c = (az_s1 >= ax_s1) && (az_s1 >= ay_s1);
	assign ysel_c = (ay_s1 >= ax_s1) && (ay_s1 >= az_s1);
	// zero counts as negative
	assign xpos_c = !x_s1[W-1] && (x_s1 != '0);
	assign ypos_c = !y_s1[W-1] && (y_s1 != '0);
	assign zpos_c = !z_s1[W-1] && (z_s1 != '0);

	always_comb begin
		if (zsel_c) begin
			m_c  = az_s1;
			vc_c = ye_c;
			if (zpos_c) begin
				face_c = FACE_POS_Z;
				uc_c   = xe_c;
			end else begin
				face_c = FACE_NEG_Z;
				uc_c   = ~xe_c + (W+1)'(1);
			end
		end else if (ysel_c) begin
			m_c  = ay_s1;
			uc_c = xe_c;
			if (ypos_c) begin
				face_c = FACE_POS_Y;
				vc_c   = ~ze_c + (W+1)'(1);
			end else begin
				face_c = FACE_NEG_Y;
				vc_c   = ze_c;
			end
		end else begin
			m_c  = ax_s1;
			vc_c = ye_c;
			if (xpos_c) begin
				face_c = FACE_POS_X;
				uc_c   = ~ze_c + (W+1)'(1);
			end else begin
				face_c = FACE_NEG_X;
				uc_c   = ze_c;
			end
		end
	end

	logic         vld_s2;
	logic [2:0]   face_s2;
	logic [W-1:0] m_s2;
	logic [W:0]   uc_s2, vc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		face_s2 <= face_c;
		m_s2    <= m_c;
		uc_s2   <= uc_c;
		vc_s2   <= vc_c;
	end

	// stage 3: shift the pair into 0..2m and flag the all-zero position
	logic [W+1:0] su_c, sv_c;

	assign su_c = {uc_s2[W], uc_s2} + {2'b00, m_s2};
	assign sv_c = {vc_s2[W], vc_s2} + {2'b00, m_s2};

	logic         vld_s3;
	logic [W-1:0] m_s3;
	logic [W:0]   su_s3, sv_s3;
	cmuvp_side_t  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s3               <= m_s2;
		su_s3              <= su_c[W:0];
		sv_s3              <= sv_c[W:0];
		side_s3.face       <= face_s2;
		side_s3.degenerate <= (m_s2 == '0);
	end

	// divider: UV_FRAC_BITS stages
	logic        div_valid;
	logic [F:0]  div_qu, div_qv;
	cmuvp_side_t div_side;

	cmuvp_div #(
		.MAG_W (W),
		.FRAC  (F)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_m      (m_s3),
		.in_su     (su_s3),
		.in_sv     (sv_s3),
		.in_side   (side_s3),
		.out_valid (div_valid),
		.out_qu    (div_qu),
		.out_qv    (div_qv),
		.out_side  (div_side)
	);

	// output register: replace the quotient by one half for a degenerate item
	logic       done_q;
	logic [F:0] u_coord_q, v_coord_q;
	logic [2:0] face_q;
	logic       degenerate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		u_coord_q    <= div_side.degenerate ? UV_HALF : div_qu;
		v_coord_q    <= div_side.degenerate ? UV_HALF : div_qv;
		face_q       <= div_side.face;
		degenerate_q <= div_side.degenerate;
	end

	assign done       = done_q;
	assign u_coord    = u_coord_q;
	assign v_coord    = v_coord_q;
	assign face       = face_q;
	assign degenerate = degenerate_q;

`ifndef SYNTHESIS
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT) done)
		else $error("accepted item did not come out on time");

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without an accepted item");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (u_coord <= UV_ONE) && (v_coord <= UV_ONE))
		else $error("texture coordinate above one");

	a_degenerate_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> (face == FACE_NEG_Z) && (u_coord == UV_HALF)
			&& (v_coord == UV_HALF))
		else $error("degenerate item with wrong face or coordinates");
`endif

endmodule

`default_nettype wire

### rtl/cmuvp_div.sv
// Pipelined restoring divider for the u and v lanes: the integer part in stage 0, then one fraction bit per stage.
// Computes floor(s * 2^(FRAC-1) / m) for s in 0..2m; uses cmuvp_pkg.
`default_nettype none

module cmuvp_div
	import cmuvp_pkg::*;
#(
	parameter int MAG_W = COORD_WIDTH_DEF,
	parameter int FRAC  = UV_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [MAG_W-1:0]  in_m,
	input  wire logic [MAG_W:0]    in_su,
	input  wire logic [MAG_W:0]    in_sv,
	input  wire cmuvp_side_t       in_side,
	output logic                   out_valid,
	output logic [FRAC:0]          out_qu,
	output logic [FRAC:0]          out_qv,
	output cmuvp_side_t            out_side
);

	// stage 0 resolves the integer part, the rest add one fraction bit each
	localparam int NST = FRAC;

	// integer part of s/m (0, 1 or 2) and the remainder below m
	function automatic logic [MAG_W+1:0] first_step(input logic [MAG_W:0] s,
			input logic [MAG_W-1:0] m);
		logic [MAG_W:0] two_m;
		logic [MAG_W:0] one_m;
		logic [MAG_W:0] d;
		logic [1:0]     q;
		two_m = {m, 1'b0};
		one_m = {1'b0, m};
		if (s >= two_m) begin
			q = 2'd2;
			d = s - two_m;
		end else if (s >= one_m) begin
			q = 2'd1;
			d = s - one_m;
		end else begin
			q = 2'd0;
			d = s;
		end
		return {q, d[MAG_W-1:0]};
	endfunction

	// one restoring step: quotient bit on top, new remainder below
	function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] r,
			input logic [MAG_W-1:0] m);
		logic [MAG_W:0] r2;
		logic [MAG_W:0] d;
		r2 = {r, 1'b0};
		d  = r2 - {1'b0, m};
		if (r2 >= {1'b0, m}) begin
			return {1'b1, d[MAG_W-1:0]};
		end
		return {1'b0, r2[MAG_W-1:0]};
	endfunction

	logic [NST-1:0]   vld_s;
	logic [MAG_W-1:0] m_s  [NST];
	logic [MAG_W-1:0] ru_s [NST];
	logic [MAG_W-1:0] rv_s [NST];
	logic [FRAC:0]    qu_s [NST];
	logic [FRAC:0]    qv_s [NST];
	cmuvp_side_t      side_s [NST];

	logic [MAG_W+1:0] fu_c;
	logic [MAG_W+1:0] fv_c;

	assign fu_c = first_step(in_su, in_m);
	assign fv_c = first_step(in_sv, in_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= in_m;
		ru_s[0]   <= fu_c[MAG_W-1:0];
		rv_s[0]   <= fv_c[MAG_W-1:0];
		qu_s[0]   <= {{(FRAC-1){1'b0}}, fu_c[MAG_W+1:MAG_W]};
		qv_s[0]   <= {{(FRAC-1){1'b0}}, fv_c[MAG_W+1:MAG_W]};
		side_s[0] <= in_side;
	end

	for (genvar k = 1; k < NST; k++) begin : g_step
		logic [MAG_W:0] su_n;
		logic [MAG_W:0] sv_n;

		assign su_n = div_step(ru_s[k-1], m_s[k-1]);
		assign sv_n = div_step(rv_s[k-1], m_s[k-1]);

		always_ff @(posedge clk) begin
			m_s[k]    <= m_s[k-1];
			ru_s[k]   <= su_n[MAG_W-1:0];
			rv_s[k]   <= sv_n[MAG_W-1:0];
			qu_s[k]   <= {qu_s[k-1][FRAC-1:0], su_n[MAG_W]};
			qv_s[k]   <= {qv_s[k-1][FRAC-1:0], sv_n[MAG_W]};
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_qu    = qu_s[NST-1];
	assign out_qv    = qv_s[NST-1];
	assign out_side  = side_s[NST-1];

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for cube_map_uv_projection: directed table then random positions.
// Predicts or looks up face, u/v and degenerate flag per item and compares against done strobes.
// Depends on cmuvp_pkg and the cube_map_uv_projection RTL.

module testbench;
	import cmuvp_pkg::*;

	localparam int CW          = COORD_WIDTH_DEF;
	localparam int UVF         = UV_FRAC_BITS_DEF;
	localparam int N_DIR       = 25;
	localparam int N_RANDOM    = 825;
	localparam int DRAIN_WAIT  = UVF + 8;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [UVF:0] u;
		logic [UVF:0] v;
		logic [2:0]   face;
		logic         degenerate;
	} uv_result_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          typed;
		uv_result_t    want;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [CW-1:0] pos_x;
	logic [CW-1:0] pos_y;
	logic [CW-1:0] pos_z;
	logic          done;
	logic [UVF:0]  u_coord;
	logic [UVF:0]  v_coord;
	logic [2:0]    face;
	logic          degenerate;

	uv_result_t pending_uv[$];
	int         mismatches = 0;
	int         cycles = 0;

	// Rows with typed=1 carry their expected result; the rest go through the predictor.
	stim_row_t dir_rows [N_DIR] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_Z, 1'b1}},
		'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_POS_X, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_X, 1'b0}},
		'{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_POS_Y, 1'b0}},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_Y, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1,
			'{17'd32768, 17'd32768, FACE_POS_Z, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_Z, 1'b0}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			'{17'd65536, 17'd65536, FACE_POS_Z, 1'b0}},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
			'{17'd65536, 17'd0, FACE_NEG_Z, 1'b0}},
		'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_X, 1'b0}},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1,
			'{17'd65535, 17'd32768, FACE_NEG_Y, 1'b0}},
		'{32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000, 1'b1,
			'{17'd65536, 17'd32768, FACE_NEG_Y, 1'b0}},
		'{32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b1,
			'{17'd65536, 17'd65536, FACE_POS_Z, 1'b0}},
		'{32'h0000_0005, 32'hFFFF_FFFB, 32'hFFFF_FFFB, 1'b1,
			'{17'd0, 17'd0, FACE_NEG_Z, 1'b0}},
		'{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_Y, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1,
			'{17'd32768, 17'd32768, FACE_NEG_Z, 1'b0}},
		'{32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0, '0},
		'{32'hFFFF_FFFD, 32'h0000_0001, 32'h0000_0002, 1'b0, '0},
		'{32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFE, 1'b0, '0},
		'{32'h0000_0001, 32'hFFFF_FFFD, 32'h0000_0002, 1'b0, '0},
		'{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0, '0},
		'{32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFD, 1'b0, '0},
		'{32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 1'b0, '0},
		'{32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0},
		'{32'h0001_0000, 32'h0000_8000, 32'hFFFF_4000, 1'b0, '0}
	};

	cube_map_uv_projection i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.done       (done),
		.u_coord    (u_coord),
		.v_coord    (v_coord),
		.face       (face),
		.degenerate (degenerate)
	);

	// floor((c + m) * 2^(UVF-1) / m), m > 0 and |c| <= m
	function automatic logic [UVF:0] coord_to_uv(longint c, longint m);
		longint s;
		s = c + m;
		return (UVF+1)'((s << (UVF - 1)) / m);
	endfunction

	function automatic uv_result_t project_vertex(logic [CW-1:0] rx, logic [CW-1:0] ry,
			logic [CW-1:0] rz);
		longint     x, y, z, ax, ay, az, m, uc, vc;
		uv_result_t r;
		x  = longint'($signed(rx));
		y  = longint'($signed(ry));
		z  = longint'($signed(rz));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		r.degenerate = 1'b0;
		// zero counts as negative; Z beats Y beats X on equal magnitude
		if (az >= ax && az >= ay) begin
			m = az;
			if (z > 0) begin
				r.face = FACE_POS_Z; uc = x; vc = y;
			end else begin
				r.face = FACE_NEG_Z; uc = -x; vc = y;
			end
		end else if (ay >= ax) begin
			m = ay;
			if (y > 0) begin
				r.face = FACE_POS_Y; uc = x; vc = -z;
			end else begin
				r.face = FACE_NEG_Y; uc = x; vc = z;
			end
		end else begin
			m = ax;
			if (x > 0) begin
				r.face = FACE_POS_X; uc = -z; vc = y;
			end else begin
				r.face = FACE_NEG_X; uc = z; vc = y;
			end
		end
		if (m == 0) begin
			r.u          = (UVF+1)'(1) << (UVF - 1);
			r.v          = (UVF+1)'(1) << (UVF - 1);
			r.face       = FACE_NEG_Z;
			r.degenerate = 1'b1;
		end else begin
			r.u = coord_to_uv(uc, m);
			r.v = coord_to_uv(vc, m);
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] random_coord();
		int t;
		t = 0;
		case ($urandom_range(0, 7))
			0, 1, 2: t = $urandom();
			3: t = int'($urandom_range(0, 200)) - 100;
			4: t = 0;
			5: t = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			6: t = int'($urandom_range(0, 131071)) - 65536;
			default: t = ($urandom() & 32'h00FF_FFFF) |
				($urandom_range(0, 1) ? 32'hFF00_0000 : 32'h0);
		endcase
		return t;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		uv_result_t exp_r;
		if (arst_n && done) begin
			if (pending_uv.size() == 0) begin
				$error("result with no item pending: u=%0d v=%0d face=%0d", u_coord,
					v_coord, face);
				mismatches++;
			end else begin
				exp_r = pending_uv.pop_front();
				if (u_coord !== exp_r.u) begin
					$error("u_coord: expected %0d, got %0d", exp_r.u, u_coord);
					mismatches++;
				end
				if (v_coord !== exp_r.v) begin
					$error("v_coord: expected %0d, got %0d", exp_r.v, v_coord);
					mismatches++;
				end
				if (face !== exp_r.face) begin
					$error("face: expected %0d, got %0d", exp_r.face, face);
					mismatches++;
				end
				if (degenerate !== exp_r.degenerate) begin
					$error("degenerate: expected %0d, got %0d", exp_r.degenerate,
						degenerate);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int            gap;
		int            pick;
		bit            burst;
		logic [CW-1:0] rx, ry, rz;
		uv_result_t    want;
		burst  = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		pos_x  = '0;
		pos_y  = '0;
		pos_z  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIR + N_RANDOM; i++) begin
			// every so often run a stretch with no gaps at all
			if (i % 100 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (i < N_DIR) begin
				rx   = dir_rows[i].x;
				ry   = dir_rows[i].y;
				rz   = dir_rows[i].z;
				want = dir_rows[i].typed ? dir_rows[i].want : project_vertex(rx, ry, rz);
			end else begin
				rx = random_coord();
				ry = random_coord();
				rz = random_coord();
				// force magnitude ties to hit the face priority
				pick = $urandom_range(0, 11);
				case (pick)
					0: ry = $urandom_range(0, 1) ? rx : -rx;
					1: rz = $urandom_range(0, 1) ? rx : -rx;
					2: rz = $urandom_range(0, 1) ? ry : -ry;
					3: begin
						ry = $urandom_range(0, 1) ? rx : -rx;
						rz = $urandom_range(0, 1) ? rx : -rx;
					end
					default: ;
				endcase
				want = project_vertex(rx, ry, rz);
			end
			start <= 1'b1;
			pos_x <= rx;
			pos_y <= ry;
			pos_z <= rz;
			@(posedge clk);
			while (busy) @(posedge clk);
			pending_uv = {pending_uv, want};
		end
		start <= 1'b0;
		while (pending_uv.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
